@@ sv/imd_pkg.sv @@
// Shared types, codes and field layout tables for the ITCH message decoder.
package imd_pkg;

  localparam int BufDepth = 45;
  localparam int CountMax = 63;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_LENGTH  = 2'd3;

  localparam logic [4:0] FID_NONE = 5'd26;
  localparam logic [7:0] SPACE    = 8'h20;

  localparam logic [7:0] MT_T = 8'h54;
  localparam logic [7:0] MT_S = 8'h53;
  localparam logic [7:0] MT_L = 8'h4C;
  localparam logic [7:0] MT_R = 8'h52;
  localparam logic [7:0] MT_H = 8'h48;
  localparam logic [7:0] MT_Y = 8'h59;
  localparam logic [7:0] MT_A = 8'h41;
  localparam logic [7:0] MT_F = 8'h46;
  localparam logic [7:0] MT_E = 8'h45;
  localparam logic [7:0] MT_D = 8'h44;
  localparam logic [7:0] MT_U = 8'h55;
  localparam logic [7:0] MT_G = 8'h47;

  localparam logic [2:0] K_U32  = 3'd0;
  localparam logic [2:0] K_U64  = 3'd1;
  localparam logic [2:0] K_CHR  = 3'd2;
  localparam logic [2:0] K_A4   = 3'd3;
  localparam logic [2:0] K_ISIN = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_frame;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [3:0]  char_count;
    logic        last_result;
  } out_t;

  // Frame descriptor handed from the front end to the field walker.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] msg_type;
  } desc_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } wr_t;

  typedef struct packed {
    logic [4:0] fid;
    logic [5:0] pos;
    logic [2:0] kind;
    logic       last;
  } fld_t;

  function automatic logic [5:0] type_len(input logic [7:0] t);
    logic [5:0] n;
    n = 6'd0;
    case (t)
      MT_T: n = 6'd5;
      MT_S: n = 6'd10;
      MT_L: n = 6'd17;
      MT_R: n = 6'd45;
      MT_H: n = 6'd14;
      MT_Y: n = 6'd14;
      MT_A: n = 6'd30;
      MT_F: n = 6'd35;
      MT_E: n = 6'd25;
      MT_D: n = 6'd13;
      MT_U: n = 6'd29;
      MT_G: n = 6'd9;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kind_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      K_U32:  n = 4'd4;
      K_U64:  n = 4'd8;
      K_CHR:  n = 4'd1;
      K_A4:   n = 4'd4;
      K_ISIN: n = 4'd12;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic fld_t mk(input int fid, input int pos, input logic [2:0] kind,
                              input logic last);
    fld_t f;
    f.fid  = 5'(fid);
    f.pos  = 6'(pos);
    f.kind = kind;
    f.last = last;
    return f;
  endfunction

  // Field layout of each message type, in message order. The ISIN counts as
  // one entry here and yields two results.
  function automatic fld_t field_info(input logic [7:0] t, input logic [3:0] k);
    fld_t f;
    f = mk(0, 1, K_U32, 1'b1);
    case (t)
      MT_T: f = mk(0, 1, K_U32, 1'b1);
      MT_S: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(2, 5, K_A4, 1'b0);
          default: f = mk(3, 9, K_CHR, 1'b1);
        endcase
      end
      MT_L: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(4, 5, K_U32, 1'b0);
          4'd2: f = mk(5, 9, K_U32, 1'b0);
          default: f = mk(6, 13, K_U32, 1'b1);
        endcase
      end
      MT_R: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(12, 5, K_A4, 1'b0);
          4'd2: f = mk(13, 9, K_ISIN, 1'b0);
          4'd3: f = mk(2, 21, K_A4, 1'b0);
          4'd4: f = mk(7, 25, K_U32, 1'b0);
          4'd5: f = mk(4, 29, K_U32, 1'b0);
          4'd6: f = mk(8, 33, K_U32, 1'b0);
          4'd7: f = mk(9, 37, K_U32, 1'b0);
          default: f = mk(10, 41, K_U32, 1'b1);
        endcase
      end
      MT_H, MT_Y: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(12, 5, K_A4, 1'b0);
          4'd2: f = mk(2, 9, K_A4, 1'b0);
          default: f = mk(11, 13, K_CHR, 1'b1);
        endcase
      end
      MT_A, MT_F: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(16, 5, K_U64, 1'b0);
          4'd2: f = mk(17, 13, K_CHR, 1'b0);
          4'd3: f = mk(18, 14, K_U32, 1'b0);
          4'd4: f = mk(12, 18, K_A4, 1'b0);
          4'd5: f = mk(2, 22, K_A4, 1'b0);
          4'd6: f = mk(19, 26, K_U32, t == MT_A);
          4'd7: f = mk(15, 30, K_A4, 1'b0);
          default: f = mk(20, 34, K_CHR, 1'b1);
        endcase
      end
      MT_E: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(16, 5, K_U64, 1'b0);
          4'd2: f = mk(21, 13, K_U32, 1'b0);
          default: f = mk(22, 17, K_U64, 1'b1);
        endcase
      end
      MT_D: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          default: f = mk(16, 5, K_U64, 1'b1);
        endcase
      end
      MT_U: begin
        case (k)
          4'd0: f = mk(1, 1, K_U32, 1'b0);
          4'd1: f = mk(23, 5, K_U64, 1'b0);
          4'd2: f = mk(24, 13, K_U64, 1'b0);
          4'd3: f = mk(18, 21, K_U32, 1'b0);
          default: f = mk(19, 25, K_U32, 1'b1);
        endcase
      end
      MT_G: f = mk(25, 1, K_U64, 1'b1);
      default: f = mk(0, 1, K_U32, 1'b1);
    endcase
    return f;
  endfunction

  // Keeps the first n bytes of a left-justified word and zeroes the rest.
  function automatic logic [63:0] alpha_mask(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n) r[63-8*j -: 8] = v[63-8*j -: 8];
    end
    return r;
  endfunction

endpackage

@@ sv/imd_front.sv @@
// Front end: gathers message bytes into the buffer and classifies each frame.
module imd_front
  import imd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  in_t   in_data,
  input  logic  back_busy,
  input  logic  desc_take,
  output logic  desc_valid,
  output desc_t desc,
  output wr_t   wr
);

  logic [5:0] byte_count_r, byte_count_nxt;
  logic [7:0] type_r, type_nxt;
  logic       desc_valid_r, desc_valid_nxt;
  desc_t      desc_r, desc_nxt;
  logic       accept;
  logic [5:0] len;
  logic [7:0] t;
  logic [5:0] want;

  assign full       = desc_valid_r | back_busy;
  assign accept     = push & ~full;
  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

  assign len  = (byte_count_r < 6'(CountMax)) ? byte_count_r + 6'd1 : byte_count_r;
  assign t    = (byte_count_r == 6'd0) ? in_data.data_byte : type_r;
  assign want = type_len(t);

  assign wr.en   = accept & ~in_data.empty_frame & (byte_count_r < 6'(BufDepth));
  assign wr.addr = byte_count_r;
  assign wr.data = in_data.data_byte;

  always_comb begin
    byte_count_nxt = byte_count_r;
    type_nxt       = type_r;
    desc_valid_nxt = desc_valid_r & ~desc_take;
    desc_nxt       = desc_r;
    if (accept) begin
      if (in_data.empty_frame) begin
        byte_count_nxt  = 6'd0;
        desc_valid_nxt  = 1'b1;
        desc_nxt.status = ST_EMPTY;
        desc_nxt.msg_type = 8'd0;
      end else begin
        type_nxt       = t;
        byte_count_nxt = len;
        if (in_data.last_byte) begin
          byte_count_nxt    = 6'd0;
          desc_valid_nxt    = 1'b1;
          desc_nxt.msg_type = t;
          if (want == 6'd0) begin
            desc_nxt.status = ST_UNKNOWN;
          end else if (len != want) begin
            desc_nxt.status = ST_LENGTH;
          end else begin
            desc_nxt.status = ST_OK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 6'd0;
      desc_valid_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      desc_valid_r <= desc_valid_nxt;
    end
    type_r <= type_nxt;
    desc_r <= desc_nxt;
  end

endmodule

@@ sv/imd_back.sv @@
// Back end: holds the message buffer and walks a frame's fields into results.
module imd_back
  import imd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  wr_t   wr,
  input  logic  desc_valid,
  input  desc_t desc,
  output logic  desc_take,
  output logic  busy,
  output logic  empty,
  input  logic  pop,
  output out_t  out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_EMIT2 = 2'd3;

  logic [7:0] mem [BufDepth];
  logic [7:0] rdata_r;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [3:0]  k_r, k_nxt;
  fld_t        fld_r, fld_nxt;
  logic [3:0]  ri_r, ri_nxt;
  logic [3:0]  di_r, di_nxt;
  logic        rv_r, rv_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] acc2_r, acc2_nxt;
  logic [3:0]  nlast_r, nlast_nxt;
  out_t        out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [3:0] flen;
  logic [5:0] raddr;
  logic       slot_free;
  logic [3:0] hi, lo;
  logic       alpha;

  assign flen      = kind_len(fld_r.kind);
  assign raddr     = fld_r.pos + {2'b00, ri_r};
  assign slot_free = ~out_valid_r | pop;
  assign hi        = (nlast_r > 4'd8) ? 4'd8 : nlast_r;
  assign lo        = (nlast_r > 4'd8) ? nlast_r - 4'd8 : 4'd0;
  assign alpha     = (fld_r.kind == K_A4) | (fld_r.kind == K_ISIN);
  assign busy      = state_r != S_IDLE;
  assign desc_take = (state_r == S_IDLE) & desc_valid;
  assign empty     = ~out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    type_nxt      = type_r;
    k_nxt         = k_r;
    fld_nxt       = fld_r;
    ri_nxt        = ri_r;
    di_nxt        = di_r;
    rv_nxt        = 1'b0;
    acc_nxt       = acc_r;
    acc2_nxt      = acc2_r;
    nlast_nxt     = nlast_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~pop;

    case (state_r)
      S_IDLE: begin
        if (desc_valid) begin
          err_nxt   = desc.status;
          type_nxt  = desc.msg_type;
          k_nxt     = 4'd0;
          fld_nxt   = field_info(desc.msg_type, 4'd0);
          ri_nxt    = 4'd0;
          di_nxt    = 4'd0;
          acc_nxt   = '0;
          acc2_nxt  = '0;
          nlast_nxt = 4'd0;
          state_nxt = (desc.status == ST_OK) ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        if (ri_r < flen) begin
          rv_nxt = 1'b1;
          ri_nxt = ri_r + 4'd1;
        end
        if (rv_r) begin
          di_nxt = di_r + 4'd1;
          if (di_r < 4'd8) begin
            acc_nxt = {acc_r[55:0], rdata_r};
          end else begin
            acc2_nxt = {acc2_r[23:0], rdata_r};
          end
          if (alpha && rdata_r != SPACE) nlast_nxt = di_r + 4'd1;
          if (di_r == flen - 4'd1) state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.msg_type     = type_r;
          out_nxt.status       = err_r;
          out_nxt.last_result  = 1'b1;
          out_nxt.field_id     = FID_NONE;
          out_nxt.field_value  = '0;
          out_nxt.char_count   = 4'd0;
          if (err_r != ST_OK) begin
            state_nxt = S_IDLE;
          end else begin
            out_nxt.field_id    = fld_r.fid;
            out_nxt.last_result = fld_r.last;
            out_nxt.field_value = acc_r;
            if (fld_r.kind == K_A4) begin
              out_nxt.field_value = alpha_mask({acc_r[31:0], 32'h0}, nlast_r);
              out_nxt.char_count  = nlast_r;
            end else if (fld_r.kind == K_ISIN) begin
              out_nxt.field_value = alpha_mask(acc_r, hi);
              out_nxt.char_count  = hi;
            end
            if (fld_r.kind == K_ISIN) begin
              state_nxt = S_EMIT2;
            end else if (fld_r.last) begin
              state_nxt = S_IDLE;
            end else begin
              k_nxt     = k_r + 4'd1;
              fld_nxt   = field_info(type_r, k_r + 4'd1);
              ri_nxt    = 4'd0;
              di_nxt    = 4'd0;
              acc_nxt   = '0;
              acc2_nxt  = '0;
              nlast_nxt = 4'd0;
              state_nxt = S_READ;
            end
          end
        end
      end
      S_EMIT2: begin
        // Second ISIN part: characters eight to eleven.
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.msg_type    = type_r;
          out_nxt.status      = ST_OK;
          out_nxt.field_id    = fld_r.fid + 5'd1;
          out_nxt.field_value = alpha_mask({acc2_r, 32'h0}, lo);
          out_nxt.char_count  = lo;
          out_nxt.last_result = 1'b0;
          k_nxt     = k_r + 4'd1;
          fld_nxt   = field_info(type_r, k_r + 4'd1);
          ri_nxt    = 4'd0;
          di_nxt    = 4'd0;
          acc_nxt   = '0;
          acc2_nxt  = '0;
          nlast_nxt = 4'd0;
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r   <= err_nxt;
    type_r  <= type_nxt;
    k_r     <= k_nxt;
    fld_r   <= fld_nxt;
    ri_r    <= ri_nxt;
    di_r    <= di_nxt;
    acc_r   <= acc_nxt;
    acc2_r  <= acc2_nxt;
    nlast_r <= nlast_nxt;
    out_r   <= out_nxt;
  end

endmodule

@@ sv/itch_message_decoder.sv @@
// Top level of the ITCH message decoder: front end, message buffer and field walker.
// Bytes are taken one per cycle while a frame is being gathered. Once the last
// byte (or an empty frame) is in, full stays high while the field walker reads
// the frame back from the buffer one byte per cycle and forms one result per
// field. The walker first takes up the frame, then for each field reads its
// bytes and emits the result, and for an ISIN emits a second result. So full
// drops once the last result of the frame is in the output register, and an
// error frame yields one result with no bytes read. Results wait in an
// output register, so the walker moves on while the previous result is still
// unread; a second result that finds the register occupied waits for pop.
module itch_message_decoder
  import imd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  logic  back_busy;
  logic  desc_take;
  logic  desc_valid;
  desc_t desc;
  wr_t   wr;

  imd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .back_busy (back_busy),
    .desc_take (desc_take),
    .desc_valid(desc_valid),
    .desc      (desc),
    .wr        (wr)
  );

  imd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .desc_valid(desc_valid),
    .desc      (desc),
    .desc_take (desc_take),
    .busy      (back_busy),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the ITCH message decoder: framed byte stimulus and field checks.
`timescale 1ns / 100ps

module tb_top;
  import imd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_t  in_data = '0;
  out_t out_data;

  itch_message_decoder dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always #4 clk = ~clk;

  localparam int StallLimit = 5000;

  in_t  pending_bytes[$];
  out_t expected_fields[$];
  logic [7:0] frame_buf[BufDepth];
  logic [5:0] frame_len;
  int   errors = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;
  bit   in_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   pop_phase = 0;

  function automatic logic [63:0] read_be(input int pos, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[55:0], frame_buf[(pos + i) % BufDepth]};
    return v;
  endfunction

  function automatic int trim_len(input int pos, input int w);
    int n;
    n = w;
    while (n > 0 && frame_buf[(pos + n - 1) % BufDepth] == SPACE) n--;
    return n;
  endfunction

  function automatic logic [63:0] pack_alpha(input int pos, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n && i < 8; i++)
      v[63 - 8 * i -: 8] = frame_buf[(pos + i) % BufDepth];
    return v;
  endfunction

  function automatic int type_len_of(input logic [7:0] t);
    case (t)
      MT_T: return 5;
      MT_S: return 10;
      MT_L: return 17;
      MT_R: return 45;
      MT_H, MT_Y: return 14;
      MT_A: return 30;
      MT_F: return 35;
      MT_E: return 25;
      MT_D: return 13;
      MT_U: return 29;
      MT_G: return 9;
      default: return 0;
    endcase
  endfunction

  task automatic add_field(input logic [1:0] st, input logic [7:0] mt, input int fid,
                           input logic [63:0] val, input int cnt);
    out_t r;
    r.status = st;
    r.msg_type = mt;
    r.field_id = 5'(fid);
    r.field_value = val;
    r.char_count = 4'(cnt);
    r.last_result = 1'b0;
    expected_fields.push_back(r);
  endtask

  task automatic add_u32(input logic [7:0] mt, input int fid, input int pos);
    add_field(ST_OK, mt, fid, read_be(pos, 4), 0);
  endtask

  task automatic add_u64(input logic [7:0] mt, input int fid, input int pos);
    add_field(ST_OK, mt, fid, read_be(pos, 8), 0);
  endtask

  task automatic add_chr(input logic [7:0] mt, input int fid, input int pos);
    add_field(ST_OK, mt, fid, {56'd0, frame_buf[pos]}, 0);
  endtask

  task automatic add_alpha(input logic [7:0] mt, input int fid, input int pos);
    int n;
    n = trim_len(pos, 4);
    add_field(ST_OK, mt, fid, pack_alpha(pos, n), n);
  endtask

  task automatic decode_frame(input int len);
    logic [7:0] t;
    int want;
    int n;
    t = frame_buf[0];
    want = type_len_of(t);
    if (want == 0) add_field(ST_UNKNOWN, t, FID_NONE, '0, 0);
    else if (len != want) add_field(ST_LENGTH, t, FID_NONE, '0, 0);
    else begin
      case (t)
        MT_T: add_u32(t, 0, 1);
        MT_S: begin
          add_u32(t, 1, 1); add_alpha(t, 2, 5); add_chr(t, 3, 9);
        end
        MT_L: begin
          add_u32(t, 1, 1); add_u32(t, 4, 5); add_u32(t, 5, 9); add_u32(t, 6, 13);
        end
        MT_R: begin
          add_u32(t, 1, 1); add_alpha(t, 12, 5);
          n = trim_len(9, 12);
          add_field(ST_OK, t, 13, pack_alpha(9, n > 8 ? 8 : n), n > 8 ? 8 : n);
          add_field(ST_OK, t, 14, pack_alpha(17, n > 8 ? n - 8 : 0), n > 8 ? n - 8 : 0);
          add_alpha(t, 2, 21); add_u32(t, 7, 25); add_u32(t, 4, 29);
          add_u32(t, 8, 33); add_u32(t, 9, 37); add_u32(t, 10, 41);
        end
        MT_H, MT_Y: begin
          add_u32(t, 1, 1); add_alpha(t, 12, 5); add_alpha(t, 2, 9); add_chr(t, 11, 13);
        end
        MT_A, MT_F: begin
          add_u32(t, 1, 1); add_u64(t, 16, 5); add_chr(t, 17, 13); add_u32(t, 18, 14);
          add_alpha(t, 12, 18); add_alpha(t, 2, 22); add_u32(t, 19, 26);
          if (t == MT_F) begin
            add_alpha(t, 15, 30); add_chr(t, 20, 34);
          end
        end
        MT_E: begin
          add_u32(t, 1, 1); add_u64(t, 16, 5); add_u32(t, 21, 13); add_u64(t, 22, 17);
        end
        MT_D: begin
          add_u32(t, 1, 1); add_u64(t, 16, 5);
        end
        MT_U: begin
          add_u32(t, 1, 1); add_u64(t, 23, 5); add_u64(t, 24, 13);
          add_u32(t, 18, 21); add_u32(t, 19, 25);
        end
        default: add_u64(t, 25, 1);
      endcase
    end
  endtask

  // Mirrors the block's buffering for one accepted byte.
  task automatic predict_byte(input in_t b);
    int len;
    if (b.empty_frame) begin
      frame_len = '0;
      add_field(ST_EMPTY, 8'd0, FID_NONE, '0, 0);
      expected_fields[$].last_result = 1'b1;
    end else begin
      if (frame_len < BufDepth) frame_buf[frame_len] = b.data_byte;
      if (frame_len < CountMax) frame_len++;
      if (b.last_byte) begin
        len = frame_len;
        frame_len = '0;
        decode_frame(len);
        expected_fields[$].last_result = 1'b1;
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic last, input logic empt);
    in_t b;
    b.data_byte = d;
    b.last_byte = last;
    b.empty_frame = empt;
    pending_bytes.push_back(b);
  endtask

  // Fills a frame of the given type and length: zeros, 0xFF, spaces or random with spaces.
  task automatic queue_frame(input logic [7:0] t, input int len, input int style);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      if (i == 0) d = t;
      else case (style)
        0: d = 8'h00;
        1: d = 8'hFF;
        2: d = SPACE;
        default: d = ($urandom_range(0, 2) == 0) ? SPACE : 8'($urandom);
      endcase
      queue_byte(d, i == len - 1, 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] types[12];
    types = '{MT_T, MT_S, MT_L, MT_R, MT_H, MT_Y, MT_A, MT_F, MT_E, MT_D, MT_U, MT_G};
    return types[$urandom_range(0, 11)];
  endfunction

  initial begin
    int kind;
    logic [7:0] t;
    frame_len = '0;
    // Directed: T, G and S frames with extreme content, the error cases, then R, F and H frames.
    queue_frame(MT_T, 5, 0);
    queue_frame(MT_G, 9, 1);
    queue_frame(MT_S, 10, 2);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_frame(MT_T, 4, 1);
    queue_frame(8'h5A, 1, 1);
    queue_byte(8'hA5, 1'b1, 1'b1);
    queue_frame(MT_T, 6, 0);
    for (int k = 0; k < 12; k++) queue_frame(pick_type(), 0, 0);
    queue_frame(MT_R, 45, 3);
    queue_frame(MT_F, 35, 3);
    queue_frame(MT_H, 14, 2);
    // A frame that overruns the buffer and saturates the count.
    queue_frame(MT_R, 70, 1);
    // A partly gathered frame dropped by an empty frame.
    queue_frame(MT_D, 3, 1);
    void'(pending_bytes.pop_back());
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    // Random part: mostly well-formed frames, some noise.
    while (pending_bytes.size() < 400) begin
      kind = $urandom_range(0, 9);
      t = pick_type();
      if (kind < 7) queue_frame(t, type_len_of(t), $urandom_range(0, 3));
      else if (kind == 7) queue_frame(t, $urandom_range(1, 50), 3);
      else if (kind == 8) queue_frame(8'($urandom), $urandom_range(1, 12), 3);
      else queue_byte(8'($urandom), 1'($urandom), 1'b1);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) void'(pending_bytes.pop_front());
      if (pending_bytes.size() == 0) begin
        push <= 1'b0;
        stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else begin
        in_data <= pending_bytes[0];
        push <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver stalls on a rotating pattern with random stretches in its second half.
  always @(negedge clk) begin
    pop_phase <= (pop_phase + 1) % 256;
    if (pop_phase < 64) pop <= 1'b1;
    else if (pop_phase < 128) pop <= (pop_phase % 3) != 0;
    else if (pop_phase < 192) pop <= $urandom_range(0, 3) == 0;
    else pop <= $urandom_range(0, 1);
  end

  always @(posedge clk) begin
    out_t want;
    in_taken <= push && !full;
    if (rst_n) begin
      if (push && !full) predict_byte(in_data);
      if (pop && !empty) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: result with none expected: %p", $realtime, out_data);
          errors++;
        end else begin
          want = expected_fields.pop_front();
          if (out_data !== want) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, want, out_data);
            errors++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && expected_fields.size() == 0) && idle_cycles < StallLimit)
      @(posedge clk);
    if (idle_cycles >= StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      repeat (100) @(posedge clk);
      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule
